FILE: rtl/crcf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crcf_pkg: shared types and constants for the CRC-16 frame unit
// Queue entry format, entry kinds, CRC constants and the byte-wide CRC update.
// ---------------------------------------------------------------------------
package crcf_pkg;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // register indexes on the csr port
   localparam logic CSR_PAYLOAD_LENGTH = 1'b0;
   localparam logic CSR_DIRECTION      = 1'b1;

   localparam logic [7:0] PAYLOAD_LENGTH_RESET = 8'd55;

   // what the back end does with one queue entry
   localparam logic [1:0] KIND_PASS     = 2'd0; // one byte out
   localparam logic [1:0] KIND_PASS_CRC = 2'd1; // byte, crc low, crc high (last)
   localparam logic [1:0] KIND_STATUS   = 2'd2; // verdict, last

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] crc;
      logic        frame_ok;
   } entry_type;

   // reflected CRC-16 update, one byte, LSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/crcf_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crcf_front: frame tracking and classification
// Holds the config registers and the frame state, updates the CRC once per accepted
// payload byte and pushes one queue entry for each item that yields output.
// ---------------------------------------------------------------------------
module crcf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [7:0]          csr_wdata,
   input  logic                req_fire,
   input  logic [7:0]          req_byte,
   output logic                push,
   output crcf_pkg::entry_type push_entry
);
   import crcf_pkg::*;

   logic [7:0]  payload_length_ff, payload_length_in;
   logic        direction_ff, direction_in;
   logic [15:0] crc_ff, crc_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  rcv_low_ff, rcv_low_in;

   logic [8:0]  len;
   logic [9:0]  pos_inc;
   logic [15:0] crc_next;

   always_comb begin
      payload_length_in = payload_length_ff;
      direction_in      = direction_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PAYLOAD_LENGTH: payload_length_in = csr_wdata;
            CSR_DIRECTION:      direction_in      = csr_wdata[0];
            default:            ;
         endcase
      end
   end

   assign len      = (payload_length_ff == 8'd0) ? 9'd256 : {1'b0, payload_length_ff};
   assign pos_inc  = {1'b0, pos_ff} + 10'd1;
   assign crc_next = crc_feed(crc_ff, req_byte);

   always_comb begin
      crc_in               = crc_ff;
      pos_in               = pos_ff;
      rcv_low_in           = rcv_low_ff;
      push                 = 1'b0;
      push_entry.kind      = KIND_PASS;
      push_entry.data_byte = req_byte;
      push_entry.crc       = crc_next;
      push_entry.frame_ok  = 1'b0;
      if (req_fire) begin
         if (!direction_ff) begin
            push = 1'b1;
            if (pos_inc >= {1'b0, len}) begin
               push_entry.kind = KIND_PASS_CRC;
               crc_in          = CRC_INIT;
               pos_in          = 9'd0;
               rcv_low_in      = 8'd0;
            end else begin
               crc_in = crc_next;
               pos_in = pos_inc[8:0];
            end
         end else if (pos_ff < len) begin
            push   = 1'b1;
            crc_in = crc_next;
            pos_in = pos_inc[8:0];
         end else if (pos_ff == len) begin
            rcv_low_in = req_byte;
            pos_in     = pos_inc[8:0];
         end else begin
            // high CRC byte: compare and close the frame
            push                 = 1'b1;
            push_entry.kind      = KIND_STATUS;
            push_entry.data_byte = 8'd0;
            push_entry.frame_ok  = ({req_byte, rcv_low_ff} == crc_ff);
            crc_in               = CRC_INIT;
            pos_in               = 9'd0;
            rcv_low_in           = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_length_ff <= PAYLOAD_LENGTH_RESET;
         direction_ff      <= 1'b0;
         crc_ff            <= CRC_INIT;
         pos_ff            <= 9'd0;
         rcv_low_ff        <= 8'd0;
      end else begin
         payload_length_ff <= payload_length_in;
         direction_ff      <= direction_in;
         crc_ff            <= crc_in;
         pos_ff            <= pos_in;
         rcv_low_ff        <= rcv_low_in;
      end
   end

endmodule

FILE: rtl/crcf_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crcf_fifo: short entry queue between front and back
// Register-based queue; push only when not full, pop only when not empty.
// ---------------------------------------------------------------------------
module crcf_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  crcf_pkg::entry_type push_entry,
   input  logic                pop,
   output crcf_pkg::entry_type head_entry,
   output logic                not_empty,
   output logic                full
);
   import crcf_pkg::*;

   entry_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;

   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/crcf_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crcf_back: result sequencer and output register
// Expands each queue entry into one or three result items.
// ---------------------------------------------------------------------------
module crcf_back (
   input  logic                clock,
   input  logic                reset,
   input  crcf_pkg::entry_type head_entry,
   input  logic                not_empty,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic [1:0]          rsp_tuser
);
   import crcf_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       status_ff, status_in;
   logic       ok_ff, ok_in;
   logic       load;
   logic       entry_done;

   assign load = not_empty && (!valid_ff || rsp_tready);

   always_comb begin
      byte_in    = head_entry.data_byte;
      last_in    = 1'b0;
      status_in  = 1'b0;
      ok_in      = 1'b0;
      entry_done = 1'b1;
      unique case (head_entry.kind)
         KIND_PASS: ;
         KIND_PASS_CRC: begin
            case (idx_ff)
               2'd0: entry_done = 1'b0;
               2'd1: begin
                  byte_in    = head_entry.crc[7:0];
                  entry_done = 1'b0;
               end
               default: begin
                  byte_in = head_entry.crc[15:8];
                  last_in = 1'b1;
               end
            endcase
         end
         KIND_STATUS: begin
            byte_in   = 8'd0;
            last_in   = 1'b1;
            status_in = 1'b1;
            ok_in     = head_entry.frame_ok;
         end
         default: ;
      endcase
   end

   assign pop = load && entry_done;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = entry_done ? 2'd0 : idx_ff + 2'd1;
      end
      valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         last_ff   <= last_in;
         status_ff <= status_in;
         ok_ff     <= ok_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {ok_ff, status_ff};

endmodule

FILE: rtl/crc16_frame_append_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc16_frame_append_check: CRC-16/MCRF4XX frame append / check unit
// Fixed-length frames, reflected poly 0x8408, init 0xFFFF, no final xor.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  req_      in         tvalid/tready         tdata[7:0] data_byte
//  rsp_      out        tvalid/tready         tdata out_byte, tlast, tuser flags
//  csr_      in         wr_en (no wait)       index 0 payload_length, 1 direction
//
//  Flow: one item per clock through the CRC update in the front while the
//  queue has room; an item is written into the queue at its accepting edge
//  and its first result item goes through the queue and the output register
//  before it is valid on rsp_. The closing payload byte of an append frame
//  gives three result items, which the output sequencer sends from one entry;
//  the 4-entry queue absorbs that and input stalls only when the queue fills.
//  Reset: synchronous, clears frame state, queue and output; payload_length
//  returns to 55 and direction to append. No clearing pass.
//  Stalls: req_tready drops only when the queue is full; rsp_tready low holds
//  the output register while the front keeps filling the queue.
//
module crc16_frame_append_check (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   // input bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   // results
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_of_frame
   output logic [1:0] rsp_tuser    // [0] is_status, [1] frame_ok
);
   import crcf_pkg::*;

   logic      req_fire;
   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type head_entry;
   logic      not_empty;
   logic      full;

   // queue has room: accept, classification happens in the same cycle
   assign req_tready = !full;
   assign req_fire   = req_tvalid && req_tready;

   crcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_fire   (req_fire),
      .req_byte   (req_tdata),
      .push       (push),
      .push_entry (push_entry)
   );

   crcf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .full       (full)
   );

   crcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // a verdict carries no byte and always closes the frame
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 8'd0 && rsp_tlast)
      else $error("status item with data or without last");

   // frame_ok is only ever set on a verdict
   a_ok_only_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("frame_ok on a byte item");

   // nothing reaches the output the cycle after reset
   a_reset_clean: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // the queue is never popped while it is empty
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

endmodule

FILE: tb/crc16_frame_append_check_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc16_frame_append_check_test: self-checking bench for the CRC-16 frame unit
// Streams byte items through append and check mode at many frame lengths and
// settings, predicts every result item in a scoreboard and compares each one
// as it leaves the block, with random idle cycles on both sides.
// ---------------------------------------------------------------------------
module crc16_frame_append_check_test;

   localparam logic [15:0] MCRF_SEED    = 16'hFFFF;
   localparam logic [15:0] MCRF_POLY    = 16'h8408;  // 0x1021, bit-reversed
   localparam logic        DIR_APPEND   = 1'b0;
   localparam logic        DIR_CHECK    = 1'b1;
   localparam int          USER_STATUS  = 0;         // rsp_tuser bit: verdict item
   localparam int          USER_OK      = 1;         // rsp_tuser bit: CRC matched
   localparam int          DRAIN_SETTLE = 8;         // queue + output register, with margin
   localparam int          DRAIN_LIMIT  = 4000;
   localparam int          ITEM_BUDGET  = 360;
   localparam int          IDLE_PCT     = 6;

   // one result item as it should leave the block
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_frame;
      logic       is_status;
      logic       frame_ok;
   } frame_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the registers and the frame state; every accepted
   // input item is turned into the result items it must produce.
   // -------------------------------------------------------------------------
   class crc_frame_scoreboard;
      logic [7:0]       payload_len;
      logic             dir;
      logic [15:0]      crc_acc;
      logic [8:0]       pos;            // index of the next byte within the frame
      logic [7:0]       crc_low_seen;   // check mode: first trailing CRC byte
      frame_result_type expected_q[$];
      int               n_items, n_results, n_errors;
      int               n_append_frames, n_good_frames, n_bad_frames;

      function new();
         payload_len     = 8'd55;
         dir             = DIR_APPEND;
         n_items         = 0;
         n_results       = 0;
         n_errors        = 0;
         n_append_frames = 0;
         n_good_frames   = 0;
         n_bad_frames    = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         crc_acc      = MCRF_SEED;
         pos          = 9'd0;
         crc_low_seen = 8'h00;
      endfunction

      // reflected CRC-16, input bits taken LSB first
      function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
         logic [15:0] r;
         r = c;
         for (int k = 0; k < 8; k++) begin
            if (r[0] ^ b[k]) begin
               r = (r >> 1) ^ MCRF_POLY;
            end else begin
               r = r >> 1;
            end
         end
         return r;
      endfunction

      // a length register of zero means 256 payload bytes
      function int cur_len();
         return (payload_len == 8'd0) ? 256 : int'(payload_len);
      endfunction

      function void write_reg(logic idx, logic [7:0] v);
         if (idx == crcf_pkg::CSR_PAYLOAD_LENGTH) begin
            payload_len = v;
         end else begin
            dir = v[0];
         end
      endfunction

      function void push_result(logic [7:0] b, logic last, logic st, logic ok);
         frame_result_type r;
         r.out_byte      = b;
         r.last_of_frame = last;
         r.is_status     = st;
         r.frame_ok      = ok;
         expected_q.push_back(r);
      endfunction

      function void note_item(logic [7:0] b);
         int   len;
         logic ok;
         len = cur_len();
         n_items++;
         if (dir == DIR_APPEND) begin
            crc_acc = crc_step(crc_acc, b);
            push_result(b, 1'b0, 1'b0, 1'b0);
            // at or past the last payload index: close the frame with the CRC
            if (int'(pos) + 1 >= len) begin
               push_result(crc_acc[7:0], 1'b0, 1'b0, 1'b0);
               push_result(crc_acc[15:8], 1'b1, 1'b0, 1'b0);
               n_append_frames++;
               restart_frame();
            end else begin
               pos = pos + 9'd1;
            end
         end else if (int'(pos) < len) begin
            crc_acc = crc_step(crc_acc, b);
            push_result(b, 1'b0, 1'b0, 1'b0);
            pos = pos + 9'd1;
         end else if (int'(pos) == len) begin
            crc_low_seen = b;           // no result item for the low CRC byte
            pos = pos + 9'd1;
         end else begin
            // any later position is the high CRC byte
            ok = ({b, crc_low_seen} == crc_acc);
            push_result(8'h00, 1'b1, 1'b1, ok);
            if (ok) begin
               n_good_frames++;
            end else begin
               n_bad_frames++;
            end
            restart_frame();
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %02h, actual %02h", name, want, got);
            n_errors++;
         end
      endfunction

      function void check_result(logic [7:0] b, logic last, logic [1:0] user);
         frame_result_type want;
         n_results++;
         if (expected_q.size() == 0) begin
            $error("result item with nothing expected: out_byte %02h last %0b user %02b",
                   b, last, user);
            n_errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("out_byte", want.out_byte, b);
         compare_field("last_of_frame", 8'(want.last_of_frame), 8'(last));
         compare_field("is_status", 8'(want.is_status), 8'(user[USER_STATUS]));
         compare_field("frame_ok", 8'(want.frame_ok), 8'(user[USER_OK]));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals
   // -------------------------------------------------------------------------
   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_index;
   logic [7:0] csr_wdata;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [1:0] rsp_tuser;

   int                  idle_pct;    // sender: chance of an idle cycle, percent
   int                  stall_pct;   // receiver: chance of a stall cycle, percent
   crc_frame_scoreboard sb;

   crc16_frame_append_check u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] data_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] out_byte
      .rsp_tlast  (rsp_tlast),    // last_of_frame
      .rsp_tuser  (rsp_tuser)     // [0] is_status, [1] frame_ok
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #2_000_000;
      $display("crc16_frame_append_check_test: errors");
      $finish;
   end

   // receiver: random stalls, updated on the falling edge only
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // result monitor: values seen at the rising edge are the ones the block held
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers. Every task is entered and left at a falling edge.
   // -------------------------------------------------------------------------
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // one input item; tvalid stays high into the next call unless it idles
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_item(b);
      @(negedge clock);
   endtask

   // whole frame from position zero; fill < 0 gives random payload bytes.
   // In check mode the trailing CRC follows, with one bit flipped if asked.
   task automatic send_frame(input int n, input int fill, input bit corrupt);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = MCRF_SEED;
      for (int k = 0; k < n; k++) begin
         b   = (fill < 0) ? rand_byte() : 8'(fill);
         crc = sb.crc_step(crc, b);
         send_byte(b);
      end
      if (sb.dir == DIR_CHECK) begin
         if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
         end
         send_byte(crc[7:0]);
         send_byte(crc[15:8]);
      end
   endtask

   // random bytes until the frame in progress has closed
   task automatic finish_frame();
      while (sb.pos != 9'd0) begin
         send_byte(rand_byte());
      end
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      sb.write_reg(idx, v);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending, wait for every expected item, then let the pipe settle
   // (a low CRC byte in check mode leaves nothing to wait for)
   task automatic drain();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_SETTLE) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int len, nframes, phase;
      reset      = 1'b1;
      csr_wr_en  = 1'b0;
      csr_index  = crcf_pkg::CSR_PAYLOAD_LENGTH;
      csr_wdata  = 8'h00;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      idle_pct   = IDLE_PCT;
      stall_pct  = IDLE_PCT;
      sb         = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: 55-byte append frame
      send_frame(sb.cur_len(), -1, 1'b0);
      drain();

      // shortest frames, all-zero and all-one payload, both modes
      write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'd1);
      send_frame(1, 8'h00, 1'b0);
      send_frame(1, 8'hFF, 1'b0);
      drain();
      write_reg(crcf_pkg::CSR_DIRECTION, DIR_CHECK);
      send_frame(1, 8'h00, 1'b0);
      send_frame(1, 8'hFF, 1'b1);    // bad CRC
      drain();
      write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'd3);
      send_frame(3, -1, 1'b0);
      drain();

      // append: length cut to the current position, next byte closes frame
      write_reg(crcf_pkg::CSR_DIRECTION, DIR_APPEND);
      write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'd4);
      repeat (2) send_byte(rand_byte());
      drain();
      write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'd2);
      send_byte(rand_byte());
      drain();

      // check: length cut past the low CRC slot, next byte is taken as CRC high
      write_reg(crcf_pkg::CSR_DIRECTION, DIR_CHECK);
      write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'd6);
      repeat (5) send_byte(rand_byte());
      drain();
      write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'd2);
      send_byte(rand_byte());
      drain();

      // direction flipped mid-frame: check turns into append
      write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'd4);
      repeat (2) send_byte(rand_byte());
      drain();
      write_reg(crcf_pkg::CSR_DIRECTION, DIR_APPEND);
      repeat (2) send_byte(rand_byte());
      drain();

      // random phases: new settings between phases, mostly well-formed frames,
      // some bad CRCs, stray bytes and frames left open across a settings change
      phase = 0;
      while (sb.n_items < ITEM_BUDGET) begin
         phase++;
         drain();
         if (phase == 2) begin
            // longest frame: length zero means 256 payload bytes, in check
            // mode, run with no idling on either side
            finish_frame();
            drain();
            write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'd0);
            write_reg(crcf_pkg::CSR_DIRECTION, DIR_CHECK);
            idle_pct  = 0;
            stall_pct = 0;
            send_frame(sb.cur_len(), -1, 1'b0);
            drain();
            idle_pct  = IDLE_PCT;
            stall_pct = IDLE_PCT;
            write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'd5);
         end else begin
            case ($urandom_range(5))
               0:       len = 1;
               1:       len = 2;
               default: len = $urandom_range(3, 16);
            endcase
            if ($urandom_range(3) != 0) begin
               write_reg(crcf_pkg::CSR_PAYLOAD_LENGTH, 8'(len));
            end
            if ($urandom_range(2) != 0) begin
               write_reg(crcf_pkg::CSR_DIRECTION, 8'($urandom_range(1)));
            end
            finish_frame();
            nframes = $urandom_range(1, 4);
            for (int f = 0; f < nframes; f++) begin
               if ($urandom_range(9) == 0) begin
                  repeat ($urandom_range(1, 4)) send_byte(rand_byte());
                  finish_frame();
               end
               send_frame(sb.cur_len(), -1, $urandom_range(4) == 0);
            end
            if ($urandom_range(2) == 0) begin
               repeat ($urandom_range(1, 3)) send_byte(rand_byte());
            end
         end
      end

      drain();
      if (sb.expected_q.size() != 0) begin
         $error("%0d expected result items never arrived", sb.expected_q.size());
         sb.n_errors++;
      end
      $display("Run: %0d input items, %0d result items, %0d random phases.",
               sb.n_items, sb.n_results, phase);
      $display("Frames: %0d append closed, %0d check verdicts (%0d matched, %0d failed).",
               sb.n_append_frames, sb.n_good_frames + sb.n_bad_frames,
               sb.n_good_frames, sb.n_bad_frames);
      if (sb.n_errors == 0) begin
         $display("crc16_frame_append_check_test: clean");
      end else begin
         $display("crc16_frame_append_check_test: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/crcf_pkg.sv
rtl/crcf_front.sv
rtl/crcf_fifo.sv
rtl/crcf_back.sv
rtl/crc16_frame_append_check.sv
tb/crc16_frame_append_check_test.sv
